// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

    // Default sizing of the table
    localparam int DEPTH_DEF       = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Fixed field widths of the request and result ports
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int ENT_W  = 32;
    localparam int CNT_W  = 5;

    // Widest entry the design supports; used for explicit extend/truncate
    localparam int WIDE_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 2'd0,
        CMD_READ     = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESOLVE
    } state_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic exec;    // capture pick/hit results this cycle
        logic write;   // append: cell at position count takes the word
        logic shift;   // remove: cells at or past index take the neighbor's word
        logic probe;   // read/remove: cell at index presents its word
        logic search;  // contains: live cells compare against the word
    } clt_ctrl_t;

endpackage

// ===== rtl/core/clt_cell.sv =====
module clt_cell
    import clt_pkg::*;
#(
    parameter int EW  = ENTRY_WIDTH_DEF,
    parameter int PW  = IDX_W,
    parameter int POS = 0
)
(
    input  logic          clk,
    input  clt_ctrl_t     ctrl,
    input  logic [PW-1:0] idx,
    input  logic [PW-1:0] cnt,
    input  logic [EW-1:0] word,
    input  logic [EW-1:0] up_data,
    output logic [EW-1:0] data,
    output logic [EW-1:0] pick,
    output logic          hit
);

    localparam logic [PW-1:0] POS_P = PW'(POS);

    logic [EW-1:0] data_reg;
    logic [EW-1:0] data_next;
    logic [EW-1:0] pick_reg;
    logic [EW-1:0] pick_next;
    logic          hit_reg;
    logic          hit_next;

    // Entry update: append write or shift-down from the upper neighbor
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.write && (POS_P == cnt))
        begin
            data_next = word;
        end
        else if (ctrl.shift && (POS_P >= idx))
        begin
            data_next = up_data;
        end
    end

    // Local read select and local match, taken from the pre-update entry
    always_comb
    begin
        pick_next = '0;
        if (ctrl.probe && (POS_P == idx))
        begin
            pick_next = data_reg;
        end
        hit_next = ctrl.search && (POS_P < cnt) && (data_reg == word);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctrl.exec)
        begin
            pick_reg <= pick_next;
            hit_reg  <= hit_next;
        end
    end

    assign data = data_reg;
    assign pick = pick_reg;
    assign hit  = hit_reg;

endmodule

// ===== rtl/core/clt_collect.sv =====
module clt_collect
    import clt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int EW    = ENTRY_WIDTH_DEF
)
(
    input  logic [DEPTH-1:0][EW-1:0] pick,
    input  logic [DEPTH-1:0]         hit,
    output logic [EW-1:0]            word_or,
    output logic                     any_hit
);

    // At most one cell presents a nonzero word, so an OR per bit column
    // merges the row into the selected entry.
    for (genvar b = 0; b < EW; b++)
    begin : g_col
        logic [DEPTH-1:0] col;
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_row
            assign col[i] = pick[i][b];
        end
        assign word_or[b] = |col;
    end

    assign any_hit = |hit;

endmodule

// ===== rtl/core/compacting_list_table.sv =====
// compacting_list_table: ordered list of entries kept in a row of register
// cells, always packed toward position zero.
// Request channel: in_valid/in_stall with command, index and value.
//   Commands: append value at the end, read at index, remove at index (later
//   entries move down one place), contains value.
// Result channel: out_valid/out_stall with status, entry, found and count.
//   Exactly one result per request; count is the live count after it.
// Steps: the request is captured when taken; in the exec step every cell
//   compares, selects and shifts in parallel and captures its result; the
//   resolve step merges the cell row into the result register once free.
// A new request is taken in the same edge its predecessor's result is
// registered, so the result register lets the next request proceed while
// the current result waits.
// When the receiver stalls, the result holds in the output register and the
// block stops taking requests once the following result is ready.
// Reset clears the live count, the sequencer and the result valid; entry
// contents are not cleared and only live positions are ever returned.
module compacting_list_table
    import clt_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [IDX_W-1:0]  index,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [ENT_W-1:0]  entry,
    output logic              found,
    output logic [CNT_W-1:0]  count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW = ENTRY_WIDTH;

    // Sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   exec_en;
    logic   ld_out;
    logic   out_free;

    // Captured request
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [EW-1:0]    val_reg;
    logic [WIDE_W-1:0] val_wide;

    // Table state and per-request status
    logic [CW-1:0] live_count_reg;
    logic [CW-1:0] live_count_next;
    stat_t         stat_reg;
    stat_t         stat_next;

    logic [PW-1:0] idx_p;
    logic [PW-1:0] cnt_p;
    logic          full;
    logic          idx_ok;
    clt_ctrl_t     ctrl;

    // Cell row
    logic [DEPTH-1:0][EW-1:0] cell_data;
    logic [DEPTH-1:0][EW-1:0] cell_pick;
    logic [DEPTH-1:0]         cell_hit;
    logic [EW-1:0]            word_or;
    logic                     any_hit;
    logic [WIDE_W-1:0]        ent_wide;
    logic [15:0]              cnt_wide;

    // Result register
    logic              out_valid_reg;
    stat_t             out_stat_reg;
    logic [ENT_W-1:0]  out_entry_reg;
    logic              out_found_reg;
    logic [CNT_W-1:0]  out_count_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        exec_en  = 1'b0;
        ld_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_EXEC:
            begin
                exec_en = 1'b1;
            end
            S_RESOLVE:
            begin
                in_stall = !out_free;
                ld_out   = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request capture
    assign val_wide = WIDE_W'(value);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            idx_reg <= index;
            val_reg <= val_wide[EW-1:0];
        end
    end

    // Request checks against the live count
    assign idx_p  = PW'(idx_reg);
    assign cnt_p  = PW'(live_count_reg);
    assign full   = (live_count_reg == CW'(DEPTH));
    assign idx_ok = (idx_p < cnt_p);

    // Cell control, count update and status
    always_comb
    begin
        ctrl            = '0;
        ctrl.exec       = exec_en;
        live_count_next = live_count_reg;
        stat_next       = STAT_OK;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    ctrl.write      = exec_en;
                    live_count_next = live_count_reg + 1'b1;
                end
            end
            CMD_READ:
            begin
                if (idx_ok)
                begin
                    ctrl.probe = exec_en;
                end
                else
                begin
                    stat_next = STAT_RANGE;
                end
            end
            CMD_REMOVE:
            begin
                if (idx_ok)
                begin
                    ctrl.probe      = exec_en;
                    ctrl.shift      = exec_en;
                    live_count_next = live_count_reg - 1'b1;
                end
                else
                begin
                    stat_next = STAT_RANGE;
                end
            end
            CMD_CONTAINS:
            begin
                ctrl.search = exec_en;
            end
            default:
            begin
                stat_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_count_reg <= '0;
        end
        else if (exec_en)
        begin
            live_count_reg <= live_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            stat_reg <= stat_next;
        end
    end

    // Row of cells; a remove shifts cells at or past the index down by one
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [EW-1:0] up_data;
        if (i == DEPTH - 1)
        begin : g_top
            assign up_data = cell_data[i];
        end
        else
        begin : g_mid
            assign up_data = cell_data[i+1];
        end

        clt_cell #(
            .EW  (EW),
            .PW  (PW),
            .POS (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .idx     (idx_p),
            .cnt     (cnt_p),
            .word    (val_reg),
            .up_data (up_data),
            .data    (cell_data[i]),
            .pick    (cell_pick[i]),
            .hit     (cell_hit[i])
        );
    end

    clt_collect #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_collect (
        .pick    (cell_pick),
        .hit     (cell_hit),
        .word_or (word_or),
        .any_hit (any_hit)
    );

    assign ent_wide = WIDE_W'(word_or);
    assign cnt_wide = 16'(live_count_reg);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_stat_reg  <= stat_reg;
            out_entry_reg <= ent_wide[ENT_W-1:0];
            out_found_reg <= any_hit;
            out_count_reg <= cnt_wide[CNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_stat_reg;
    assign entry     = out_entry_reg;
    assign found     = out_found_reg;
    assign count     = out_count_reg;

    // Live count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CW'(DEPTH))
        else $error("live count exceeds depth");

    // A successful append grows the list by exactly one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg == CMD_APPEND && !full)
        |=> live_count_reg == CW'($past(live_count_reg) + 1'b1))
        else $error("append did not grow the list");

    // A result only appears out of the resolve step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESOLVE)
        else $error("result raised outside resolve");

    // A match is only ever reported with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |-> out_stat_reg == STAT_OK)
        else $error("found set with error status");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import clt_pkg::*;

    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 60;    // long receiver hold-off under pressure

    // One result as the block reports it
    typedef struct packed {
        stat_t             status;
        logic [ENT_W-1:0]  entry;
        logic              found;
        logic [CNT_W-1:0]  count;
    } table_result_t;

    // Directed stimulus row; typed result used only where known is set
    typedef struct {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        bit                known;
        table_result_t     result;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
    logic              out_valid;
    logic              out_stall;
    logic [STAT_W-1:0] status;
    logic [ENT_W-1:0]  entry;
    logic              found;
    logic [CNT_W-1:0]  count;

    // Mirror of the list contents and live count
    logic [ENT_W-1:0]  mirror_words [DEPTH_DEF];
    int                mirror_count;

    table_result_t     pending_results [$];
    directed_row_t     directed_rows [$];

    int  error_count;
    int  idle_pct;
    int  stall_pct;
    int  hold_request;
    int  quiet_cycles;
    bit  fill_bias;

    // Run statistics
    int  cmd_seen [4];
    int  results_checked;
    int  full_seen;
    int  range_seen;
    int  hits_seen;
    int  backpressure_cycles;
    int  peak_count;

    compacting_list_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .entry     (entry),
        .found     (found),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Apply one request to the mirror and return what the block must answer
    function automatic table_result_t apply_request(cmd_t c, logic [IDX_W-1:0] i,
                                                    logic [VAL_W-1:0] v);
        table_result_t r;
        int            k;
        r = '{status: STAT_OK, entry: '0, found: 1'b0, count: '0};
        case (c)
            CMD_APPEND:
            begin
                if (mirror_count >= DEPTH_DEF)
                    r.status = STAT_FULL;
                else
                begin
                    mirror_words[mirror_count] = v;
                    mirror_count++;
                end
            end
            CMD_READ:
            begin
                if (int'(i) < mirror_count)
                    r.entry = mirror_words[i];
                else
                    r.status = STAT_RANGE;
            end
            CMD_REMOVE:
            begin
                if (int'(i) < mirror_count)
                begin
                    r.entry = mirror_words[i];
                    // later entries close the gap
                    for (k = int'(i); k + 1 < mirror_count; k++)
                        mirror_words[k] = mirror_words[k + 1];
                    mirror_count--;
                end
                else
                    r.status = STAT_RANGE;
            end
            default:
            begin
                for (k = 0; k < mirror_count; k++)
                    if (mirror_words[k] == v)
                        r.found = 1'b1;
            end
        endcase
        r.count = mirror_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(cmd_t c, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v,
                                    bit known, stat_t st, logic [ENT_W-1:0] ent,
                                    logic fnd, logic [CNT_W-1:0] cnt);
        directed_row_t row;
        row.cmd    = c;
        row.idx    = i;
        row.val    = v;
        row.known  = known;
        row.result = '{status: st, entry: ent, found: fnd, count: cnt};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [ENT_W-1:0] got,
                                   logic [ENT_W-1:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one request (called at a falling edge, returns at one)
    task automatic send_request(cmd_t c, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v,
                                bit known, table_result_t typed);
        table_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        index    <= i;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_request(c, i, v);
        pending_results.push_back(known ? typed : predicted);
        cmd_seen[c]++;
        if (predicted.status == STAT_FULL)
            full_seen++;
        if (predicted.status == STAT_RANGE)
            range_seen++;
        if (predicted.found)
            hits_seen++;
        if (mirror_count > peak_count)
            peak_count = mirror_count;
        @(negedge clk);
    endtask

    // Random request shaped by the current live count
    task automatic send_random_request();
        cmd_t              c;
        logic [IDX_W-1:0]  i;
        logic [VAL_W-1:0]  v;
        int                pick;
        // swing the list between empty and full
        if (mirror_count == DEPTH_DEF && $urandom_range(3) == 0)
            fill_bias = 1'b0;
        else if (mirror_count == 0)
            fill_bias = 1'b1;
        else if ($urandom_range(29) == 0)
            fill_bias = ~fill_bias;
        pick = $urandom_range(99);
        if (fill_bias)
            c = (pick < 55) ? CMD_APPEND : (pick < 75) ? CMD_READ :
                (pick < 85) ? CMD_REMOVE : CMD_CONTAINS;
        else
            c = (pick < 15) ? CMD_APPEND : (pick < 40) ? CMD_READ :
                (pick < 75) ? CMD_REMOVE : CMD_CONTAINS;
        if (mirror_count > 0 && $urandom_range(99) < 80)
            i = IDX_W'($urandom_range(mirror_count - 1));
        else
            i = IDX_W'($urandom);
        // small pool of values gives duplicates for contains
        v = ($urandom_range(3) == 0) ? VAL_W'($urandom_range(7)) : VAL_W'($urandom);
        if (c == CMD_CONTAINS && mirror_count > 0 && $urandom_range(1) == 0)
            v = mirror_words[$urandom_range(mirror_count - 1)];
        send_request(c, i, v, 1'b0, '0);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request pending", entry, '0);
            else
            begin
                table_result_t want;
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", ENT_W'(status), ENT_W'(want.status));
                if (entry !== want.entry)
                    report_mismatch("entry", entry, want.entry);
                if (found !== want.found)
                    report_mismatch("found", ENT_W'(found), ENT_W'(want.found));
                if (count !== want.count)
                    report_mismatch("count", ENT_W'(count), ENT_W'(want.count));
                results_checked++;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on demand
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            backpressure_cycles++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles with no handshake", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_APPEND;
        index        = '0;
        value        = '0;
        error_count  = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        quiet_cycles = 0;
        fill_bias    = 1'b1;
        mirror_count = 0;
        results_checked = 0;
        full_seen    = 0;
        range_seen   = 0;
        hits_seen    = 0;
        backpressure_cycles = 0;
        peak_count   = 0;
        for (k = 0; k < 4; k++)
            cmd_seen[k] = 0;
        for (k = 0; k < DEPTH_DEF; k++)
            mirror_words[k] = '0;

        // empty list: every index is out of range, nothing is found
        add_row(CMD_READ,     4'd0,  32'h0,        1, STAT_RANGE, '0, 1'b0, 5'd0);
        add_row(CMD_REMOVE,   4'd15, 32'h0,        1, STAT_RANGE, '0, 1'b0, 5'd0);
        add_row(CMD_CONTAINS, 4'd0,  32'h0,        1, STAT_OK,    '0, 1'b0, 5'd0);
        // fill to capacity, extremes first
        add_row(CMD_APPEND,   4'd0,  32'hFFFFFFFF, 1, STAT_OK,    '0, 1'b0, 5'd1);
        add_row(CMD_APPEND,   4'd15, 32'h00000000, 1, STAT_OK,    '0, 1'b0, 5'd2);
        for (k = 3; k <= DEPTH_DEF; k++)
            add_row(CMD_APPEND, IDX_W'(k), {16'h5A00 + 16'(k), 16'hC300 + 16'(k)},
                    1, STAT_OK, '0, 1'b0, CNT_W'(k));
        // append to a full list is refused
        add_row(CMD_APPEND,   4'd0,  32'h12345678, 1, STAT_FULL,  '0, 1'b0, 5'd16);
        add_row(CMD_READ,     4'd15, 32'h0,        0, STAT_OK,    '0, 1'b0, '0);
        add_row(CMD_CONTAINS, 4'd0,  32'h00000000, 0, STAT_OK,    '0, 1'b0, '0);
        add_row(CMD_CONTAINS, 4'd0,  32'h12345678, 0, STAT_OK,    '0, 1'b0, '0);
        // remove the head (shift) and then the last live entry (no live entry moves)
        add_row(CMD_REMOVE,   4'd0,  32'h0,        0, STAT_OK,    '0, 1'b0, '0);
        add_row(CMD_REMOVE,   4'd14, 32'h0,        0, STAT_OK,    '0, 1'b0, '0);
        add_row(CMD_READ,     4'd14, 32'hFFFFFFFF, 1, STAT_RANGE, '0, 1'b0, 5'd14);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_rows[r])
            send_request(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].val,
                         directed_rows[r].known, directed_rows[r].result);

        // random phases with different idling mixes
        idle_pct = 0;  stall_pct = 0;
        repeat (440) send_random_request();
        idle_pct = 51; stall_pct = 0;
        repeat (440) send_random_request();
        idle_pct = 0;  stall_pct = 51;
        repeat (440) send_random_request();
        idle_pct = 22; stall_pct = 22;
        repeat (440) send_random_request();

        // long receiver hold-off while requests keep coming
        idle_pct = 0;  stall_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_request();

        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests: %0d append, %0d read, %0d remove, %0d contains; %0d results",
                 cmd_seen[CMD_APPEND] + cmd_seen[CMD_READ] + cmd_seen[CMD_REMOVE]
                 + cmd_seen[CMD_CONTAINS], cmd_seen[CMD_APPEND], cmd_seen[CMD_READ],
                 cmd_seen[CMD_REMOVE], cmd_seen[CMD_CONTAINS], results_checked);
        $display("Refused appends %0d, out-of-range %0d, hits %0d, peak count %0d, %0d held cycles",
                 full_seen, range_seen, hits_seen, peak_count, backpressure_cycles);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/clt_pkg.sv
rtl/core/clt_cell.sv
rtl/core/clt_collect.sv
rtl/core/compacting_list_table.sv
sim/testbench.sv
